[design/bspline_curve_point_assert.svh]
// Assertion macros shared by the checker of the B-spline curve point block.
// Depends on nothing; a file that asserts includes it before its module.
`ifndef BSPLINE_CURVE_POINT_ASSERT_SVH
`define BSPLINE_CURVE_POINT_ASSERT_SVH

// Same-cycle implication, disabled while reset is low.
`define BSCP_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is low.
`define BSCP_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[design/bscp_pkg.sv]
// Package of the B-spline curve point block: fixed-point widths, codes,
// controller states, datapath commands and status. Depends on nothing.
package bscp_pkg;

    // Parameter t keeps 16 fraction bits, basis values keep 28.
    localparam int FRAC_T = 16;
    localparam int BFRAC  = 28;
    localparam int NBW    = BFRAC + 1;          // basis value, up to 1.0
    localparam int XW     = FRAC_T + 2;         // knot distance, below 4.0
    localparam int PW     = XW + NBW;           // distance times basis
    localparam int QW     = PW - FRAC_T - 1;    // product over 2^16, below 3*2^28
    localparam int RW     = 31;                 // reciprocal of three
    localparam int MW     = QW + RW;            // quotient estimate product
    localparam int ACCW   = 64;                 // weighted sum accumulator
    localparam int SPW    = 32 + NBW + 1;       // point times basis
    localparam int RNDW   = ACCW - BFRAC;       // sum after the rounding shift

    localparam logic [NBW-1:0] NB_ONE  = NBW'(1) << BFRAC;
    localparam logic [RW-1:0]  RECIP3  = 31'd1431655765;  // floor(2^32 / 3)
    localparam logic [ACCW-1:0] RND_HALF = ACCW'(1) << (BFRAC - 1);

    // Configuration port.
    localparam int CFG_IW = 4;
    localparam int CFG_DW = 8;
    localparam logic [CFG_IW-1:0] CFG_POINT_COUNT   = 4'd0;
    localparam logic [CFG_IW-1:0] CFG_SPLINE_DEGREE = 4'd1;

    // Item kinds.
    localparam logic OPC_WRITE = 1'b0;
    localparam logic OPC_EVAL  = 1'b1;

    typedef enum logic [3:0] {
        ST_IDLE, ST_PREP, ST_EP_RD, ST_INIT, ST_LVL_RD, ST_LVL_LD,
        ST_MUL, ST_DIV, ST_FIX, ST_SUM_CLR, ST_SUM_RD, ST_SUM_MUL,
        ST_SUM_ACC, ST_OUT_BAD, ST_OUT_EP, ST_OUT_SUM
    } t_state;

    typedef enum logic [4:0] {
        OP_NONE, OP_WRITE, OP_CAPTURE, OP_PREP, OP_EP_READ, OP_INIT,
        OP_LVL_READ, OP_LVL_LOAD, OP_MUL, OP_DIV, OP_FIX, OP_SUM_CLR,
        OP_SUM_READ, OP_SUM_MUL, OP_SUM_ACC, OP_LOAD_BAD, OP_LOAD_EP,
        OP_LOAD_SUM
    } t_op;

    typedef struct packed {
        logic bad;          // count does not exceed degree
        logic t_edge;       // t at or beyond an end of the curve
        logic deg_zero;     // degree zero, no recursion
        logic last_init;    // last degree-zero basis entry
        logic last_step;    // last term of the current recursion level
        logic last_level;   // current level is the degree
        logic last_sum;     // last control point of the weighted sum
        logic out_free;     // result register can take a new beat
    } t_status;

endpackage

[design/bscp_ctrl.sv]
// Sequencer of the B-spline curve point block: accepts items and steps the
// datapath through setup, basis recursion, weighted sum and result. Uses bscp_pkg.
module bscp_ctrl import bscp_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    input  logic    i_opcode,
    output logic    o_in_ready,
    input  t_status i_status,
    output t_op     o_op
);

    t_state r_state, n_state;

    // State register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state and datapath command.
    always_comb begin
        n_state    = r_state;
        o_op       = OP_NONE;
        o_in_ready = 1'b0;
        case (r_state)
            ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    if (i_opcode == OPC_EVAL) begin
                        o_op    = OP_CAPTURE;
                        n_state = ST_PREP;
                    end else begin
                        o_op = OP_WRITE;
                    end
                end
            end
            ST_PREP: begin
                o_op = OP_PREP;
                if (i_status.bad) begin
                    n_state = ST_OUT_BAD;
                end else if (i_status.t_edge) begin
                    n_state = ST_EP_RD;
                end else begin
                    n_state = ST_INIT;
                end
            end
            ST_EP_RD: begin
                o_op    = OP_EP_READ;
                n_state = ST_OUT_EP;
            end
            ST_INIT: begin
                o_op = OP_INIT;
                if (i_status.last_init) begin
                    n_state = i_status.deg_zero ? ST_SUM_CLR : ST_LVL_RD;
                end
            end
            ST_LVL_RD: begin
                o_op    = OP_LVL_READ;
                n_state = ST_LVL_LD;
            end
            ST_LVL_LD: begin
                o_op    = OP_LVL_LOAD;
                n_state = ST_MUL;
            end
            ST_MUL: begin
                o_op    = OP_MUL;
                n_state = ST_DIV;
            end
            ST_DIV: begin
                o_op    = OP_DIV;
                n_state = ST_FIX;
            end
            ST_FIX: begin
                o_op = OP_FIX;
                if (!i_status.last_step) begin
                    n_state = ST_MUL;
                end else if (i_status.last_level) begin
                    n_state = ST_SUM_CLR;
                end else begin
                    n_state = ST_LVL_RD;
                end
            end
            ST_SUM_CLR: begin
                o_op    = OP_SUM_CLR;
                n_state = ST_SUM_RD;
            end
            ST_SUM_RD: begin
                o_op    = OP_SUM_READ;
                n_state = ST_SUM_MUL;
            end
            ST_SUM_MUL: begin
                o_op    = OP_SUM_MUL;
                n_state = ST_SUM_ACC;
            end
            ST_SUM_ACC: begin
                o_op    = OP_SUM_ACC;
                n_state = i_status.last_sum ? ST_OUT_SUM : ST_SUM_RD;
            end
            ST_OUT_BAD: begin
                if (i_status.out_free) begin
                    o_op    = OP_LOAD_BAD;
                    n_state = ST_IDLE;
                end
            end
            ST_OUT_EP: begin
                if (i_status.out_free) begin
                    o_op    = OP_LOAD_EP;
                    n_state = ST_IDLE;
                end
            end
            ST_OUT_SUM: begin
                if (i_status.out_free) begin
                    o_op    = OP_LOAD_SUM;
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

endmodule

[design/bscp_datapath.sv]
// Datapath of the B-spline curve point block: configuration registers, point
// and basis memories, recursion arithmetic, weighted sum and result register.
// Uses bscp_pkg; driven by bscp_ctrl commands.
module bscp_datapath import bscp_pkg::*; #(
    parameter int MAX_POINTS = 16,
    parameter int MAX_DEGREE = 3
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_op               i_op,
    input  logic              i_cfg_valid,
    input  logic [CFG_IW-1:0] i_cfg_index,
    input  logic [CFG_DW-1:0] i_cfg_data,
    input  logic [3:0]        i_point_index,
    input  logic [31:0]       i_point_x,
    input  logic [31:0]       i_point_y,
    input  logic [17:0]       i_param_t,
    input  logic              i_out_ready,
    output t_status           o_status,
    output logic              o_out_valid,
    output logic [31:0]       o_curve_x,
    output logic [31:0]       o_curve_y,
    output logic              o_bad_degree
);

    localparam int KNOT_SLOTS = MAX_POINTS + MAX_DEGREE + 1;
    localparam int CW  = $clog2(MAX_POINTS + 1);
    localparam int IW  = $clog2(KNOT_SLOTS + 1);
    localparam int NAW = $clog2(KNOT_SLOTS);
    localparam int PAW = $clog2(MAX_POINTS);
    localparam int UW  = FRAC_T + CW;

    // Knot value in units of one interior span.
    function automatic logic [CW-1:0] knot_val(input logic [IW-1:0] idx,
                                              input logic [1:0] deg,
                                              input logic [CW-1:0] cnt);
        logic [CW-1:0] span_cnt;
        span_cnt = cnt - CW'(deg);
        if (idx <= IW'(deg)) begin
            knot_val = '0;
        end else if (idx >= IW'(cnt)) begin
            knot_val = span_cnt;
        end else begin
            knot_val = CW'(idx - IW'(deg));
        end
    endfunction

    // One recursion term divided by its span of one, two or three.
    function automatic logic [NBW-1:0] span_div(input logic [QW-1:0] q,
                                               input logic [NBW-1:0] est,
                                               input logic [1:0] d);
        logic [QW-1:0] rem;
        rem = q - (QW'(est) + (QW'(est) << 1));
        case (d)
            2'd0:    span_div = '0;
            2'd1:    span_div = q[NBW-1:0];
            2'd2:    span_div = q[NBW:1];
            2'd3:    span_div = (rem >= QW'(3)) ? est + NBW'(1) : est;
            default: span_div = '0;
        endcase
    endfunction

    logic [4:0]       r_point_count;
    logic [1:0]       r_spline_degree;
    logic [CW-1:0]    r_cnt;
    logic [1:0]       r_deg;
    logic [17:0]      r_t;
    logic [UW-1:0]    r_u;
    logic [IW-1:0]    r_i;
    logic [1:0]       r_p;
    logic [63:0]      r_pt_mem [MAX_POINTS];
    logic [63:0]      r_pt_rd;
    logic [NBW-1:0]   r_nb_mem [KNOT_SLOTS];
    logic [NBW-1:0]   r_nb_rd;
    logic [NBW-1:0]   r_lo;
    logic [NBW-1:0]   r_hi;
    logic [PW-1:0]    r_p1, r_p2;
    logic [QW-1:0]    r_q1, r_q2;
    logic [NBW-1:0]   r_e1, r_e2;
    logic signed [SPW-1:0]  r_px, r_py;
    logic signed [ACCW-1:0] r_acc_x, r_acc_y;
    logic             r_out_valid;
    logic [31:0]      r_out_x, r_out_y;
    logic             r_out_bad;

    logic [CW-1:0]    w_m;
    logic [IW-1:0]    w_kc;
    logic [IW-1:0]    w_ip;
    logic [CW-1:0]    w_ki, w_ki1, w_kip, w_kip1;
    logic [1:0]       w_d1, w_d2;
    logic [UW-1:0]    w_x1_full, w_x2_full;
    logic [XW-1:0]    w_x1, w_x2;
    logic [MW-1:0]    w_m1, w_m2;
    logic [QW-1:0]    w_q1, w_q2;
    logic [NBW-1:0]   w_term;
    logic             w_in_span;
    logic             w_t_le0;
    logic             w_nb_rd_en;
    logic [NAW-1:0]   w_nb_raddr;
    logic             w_pt_rd_en;
    logic [PAW-1:0]   w_pt_raddr;
    logic [31:0]      w_rnd_x, w_rnd_y;

    // Saturating round of a Q.44 sum to Q16.16.
    function automatic logic [31:0] round_sat(input logic signed [ACCW-1:0] s);
        logic [ACCW-1:0] sr;
        logic [RNDW-1:0] r;
        sr = ACCW'(s) + RND_HALF;
        r  = sr[ACCW-1:BFRAC];
        if (!r[RNDW-1] && (|r[RNDW-2:31])) begin
            round_sat = 32'h7FFF_FFFF;
        end else if (r[RNDW-1] && !(&r[RNDW-2:31])) begin
            round_sat = 32'h8000_0000;
        end else begin
            round_sat = r[31:0];
        end
    endfunction

    // Configuration registers; writes to unknown indexes are dropped.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_point_count   <= 5'd4;
            r_spline_degree <= 2'd3;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_POINT_COUNT:   r_point_count   <= i_cfg_data[4:0];
                CFG_SPLINE_DEGREE: r_spline_degree <= i_cfg_data[1:0];
                default: ;
            endcase
        end
    end

    // Knot indexes and spans of the current recursion term.
    assign w_m    = r_cnt - CW'(r_deg);
    assign w_kc   = IW'(r_cnt) + IW'(r_deg) + IW'(1);
    assign w_ip   = r_i + IW'(r_p);
    assign w_ki   = knot_val(r_i, r_deg, r_cnt);
    assign w_ki1  = knot_val(r_i + IW'(1), r_deg, r_cnt);
    assign w_kip  = knot_val(w_ip, r_deg, r_cnt);
    assign w_kip1 = knot_val(w_ip + IW'(1), r_deg, r_cnt);
    assign w_d1   = 2'(w_kip - w_ki);
    assign w_d2   = 2'(w_kip1 - w_ki1);

    // Distances of u from the span ends; exact wherever the basis is nonzero.
    assign w_x1_full = r_u - {w_ki, FRAC_T'(0)};
    assign w_x2_full = {w_kip1, FRAC_T'(0)} - r_u;
    assign w_x1      = w_x1_full[XW-1:0];
    assign w_x2      = w_x2_full[XW-1:0];

    // Degree-zero basis: one where u lies in [knot i, knot i+1).
    assign w_in_span = (r_u >= {w_ki, FRAC_T'(0)}) && (r_u < {w_ki1, FRAC_T'(0)});

    // Quotient estimates for a span of three.
    assign w_q1 = r_p1[PW-2:FRAC_T];
    assign w_q2 = r_p2[PW-2:FRAC_T];
    assign w_m1 = w_q1 * RECIP3;
    assign w_m2 = w_q2 * RECIP3;
    assign w_term = span_div(r_q1, r_e1, w_d1) + span_div(r_q2, r_e2, w_d2);

    assign w_t_le0 = r_t[17] || (r_t == 18'd0);

    // Read ports of the two memories.
    always_comb begin
        w_nb_rd_en = 1'b0;
        w_nb_raddr = NAW'(r_i);
        w_pt_rd_en = 1'b0;
        w_pt_raddr = PAW'(r_i);
        case (i_op)
            OP_LVL_READ: begin
                w_nb_rd_en = 1'b1;
                w_nb_raddr = '0;
            end
            OP_LVL_LOAD: begin
                w_nb_rd_en = 1'b1;
                w_nb_raddr = NAW'(r_i + IW'(1));
            end
            OP_FIX: begin
                w_nb_rd_en = 1'b1;
                w_nb_raddr = NAW'(r_i + IW'(2));
            end
            OP_SUM_READ: begin
                w_nb_rd_en = 1'b1;
                w_pt_rd_en = 1'b1;
            end
            OP_EP_READ: begin
                w_pt_rd_en = 1'b1;
                w_pt_raddr = w_t_le0 ? '0 : PAW'(r_cnt - CW'(1));
            end
            default: ;
        endcase
    end

    // Control point memory, x in the low half.
    always_ff @(posedge i_clk) begin
        if (i_op == OP_WRITE && 32'(i_point_index) < MAX_POINTS) begin
            r_pt_mem[PAW'(i_point_index)] <= {i_point_y, i_point_x};
        end
        if (w_pt_rd_en) begin
            r_pt_rd <= r_pt_mem[w_pt_raddr];
        end
    end

    // Basis memory, rewritten in place level by level.
    always_ff @(posedge i_clk) begin
        if (i_op == OP_INIT) begin
            r_nb_mem[NAW'(r_i)] <= w_in_span ? NB_ONE : '0;
        end else if (i_op == OP_FIX) begin
            r_nb_mem[NAW'(r_i)] <= w_term;
        end
        if (w_nb_rd_en) begin
            r_nb_rd <= r_nb_mem[w_nb_raddr];
        end
    end

    // Item capture, scaled parameter and counters.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_i <= '0;
            r_p <= 2'd1;
        end else begin
            case (i_op)
                OP_PREP:     begin r_i <= '0; r_p <= 2'd1; end
                OP_INIT:     r_i <= r_i + IW'(1);
                OP_LVL_READ: r_i <= '0;
                OP_FIX: begin
                    r_i <= r_i + IW'(1);
                    if (o_status.last_step) begin
                        r_p <= r_p + 2'd1;
                    end
                end
                OP_SUM_CLR:  r_i <= '0;
                OP_SUM_ACC:  r_i <= r_i + IW'(1);
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_op == OP_CAPTURE) begin
            r_cnt <= (32'(r_point_count) > MAX_POINTS) ? CW'(MAX_POINTS)
                                                      : CW'(r_point_count);
            r_deg <= (32'(r_spline_degree) > MAX_DEGREE) ? 2'(MAX_DEGREE)
                                                        : r_spline_degree;
            r_t   <= i_param_t;
        end
        if (i_op == OP_PREP) begin
            r_u <= r_t[FRAC_T-1:0] * w_m;
        end
    end

    // Recursion pipeline: products, quotient estimates, correction.
    always_ff @(posedge i_clk) begin
        if (i_op == OP_LVL_LOAD) begin
            r_lo <= r_nb_rd;
        end
        if (i_op == OP_MUL) begin
            r_hi <= r_nb_rd;
            r_p1 <= w_x1 * r_lo;
            r_p2 <= w_x2 * r_nb_rd;
        end
        if (i_op == OP_DIV) begin
            r_q1 <= w_q1;
            r_q2 <= w_q2;
            r_e1 <= w_m1[MW-1:32];
            r_e2 <= w_m2[MW-1:32];
        end
        if (i_op == OP_FIX) begin
            r_lo <= r_hi;
        end
    end

    // Weighted sum of the control points.
    always_ff @(posedge i_clk) begin
        if (i_op == OP_SUM_MUL) begin
            r_px <= $signed(r_pt_rd[31:0])  * $signed({1'b0, r_nb_rd});
            r_py <= $signed(r_pt_rd[63:32]) * $signed({1'b0, r_nb_rd});
        end
        if (i_op == OP_SUM_CLR) begin
            r_acc_x <= '0;
            r_acc_y <= '0;
        end else if (i_op == OP_SUM_ACC) begin
            r_acc_x <= r_acc_x + ACCW'(r_px);
            r_acc_y <= r_acc_y + ACCW'(r_py);
        end
    end

    assign w_rnd_x = round_sat(r_acc_x);
    assign w_rnd_y = round_sat(r_acc_y);

    // Result register; a beat waits here while the next item is taken.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_op == OP_LOAD_BAD || i_op == OP_LOAD_EP || i_op == OP_LOAD_SUM) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        case (i_op)
            OP_LOAD_BAD: begin
                r_out_x <= '0;
                r_out_y <= '0;
                r_out_bad <= 1'b1;
            end
            OP_LOAD_EP: begin
                r_out_x <= r_pt_rd[31:0];
                r_out_y <= r_pt_rd[63:32];
                r_out_bad <= 1'b0;
            end
            OP_LOAD_SUM: begin
                r_out_x <= w_rnd_x;
                r_out_y <= w_rnd_y;
                r_out_bad <= 1'b0;
            end
            default: ;
        endcase
    end

    // Status toward the sequencer.
    assign o_status.bad        = (r_cnt <= CW'(r_deg));
    assign o_status.t_edge     = w_t_le0 || r_t[FRAC_T];
    assign o_status.deg_zero   = (r_deg == 2'd0);
    assign o_status.last_init  = (r_i + IW'(2) == w_kc);
    assign o_status.last_step  = (w_ip + IW'(2) == w_kc);
    assign o_status.last_level = (r_p == r_deg);
    assign o_status.last_sum   = (r_i + IW'(1) == IW'(r_cnt));
    assign o_status.out_free   = !r_out_valid || i_out_ready;

    assign o_out_valid  = r_out_valid;
    assign o_curve_x    = r_out_x;
    assign o_curve_y    = r_out_y;
    assign o_bad_degree = r_out_bad;

endmodule

[design/bspline_curve_point.sv]
// Top level of the open uniform B-spline curve point block.
// Instantiates bscp_ctrl and bscp_datapath; uses bscp_pkg.
//
//  Channel   Dir  Beat contents
//  s_axis    in   tuser: opcode; tdata: point_index, point_x, point_y, param_t
//  m_axis    out  tuser: bad_degree; tdata: curve_x, curve_y
//  cfg       in   i_cfg_index selects point_count (0) or spline_degree (1)
//
// An evaluation that hits the bad-degree case or an end of the curve loads a zero point
// or the first or last control point as its result; otherwise it builds the degree-zero basis,
// then each recursion level one basis term at a time on the shared recursion unit,
// then the weighted sum of the control points.
// Reset is synchronous and active low; it restores count 4, degree 3.
// A finished result waits in the output register without blocking the next item.
module bspline_curve_point import bscp_pkg::*; #(
    parameter int MAX_POINTS = 16,
    parameter int MAX_DEGREE = 3
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              s_axis_tvalid,
    output logic              s_axis_tready,
    input  logic [87:0]       s_axis_tdata,   // point_index, point_x, point_y, param_t, pad
    input  logic              s_axis_tuser,   // opcode
    output logic              m_axis_tvalid,
    input  logic              m_axis_tready,
    output logic [63:0]       m_axis_tdata,   // curve_x, curve_y
    output logic              m_axis_tuser,   // bad_degree
    input  logic              i_cfg_valid,
    output logic              o_cfg_ready,
    input  logic [CFG_IW-1:0] i_cfg_index,
    input  logic [CFG_DW-1:0] i_cfg_data
);

    t_op         w_op;
    t_status     w_status;
    logic [31:0] w_curve_x, w_curve_y;

    // Registers are always writable.
    assign o_cfg_ready = 1'b1;

    bscp_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .i_opcode   (s_axis_tuser),
        .o_in_ready (s_axis_tready),
        .i_status   (w_status),
        .o_op       (w_op)
    );

    bscp_datapath #(
        .MAX_POINTS (MAX_POINTS),
        .MAX_DEGREE (MAX_DEGREE)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_op          (w_op),
        .i_cfg_valid   (i_cfg_valid),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .i_point_index (s_axis_tdata[3:0]),
        .i_point_x     (s_axis_tdata[35:4]),
        .i_point_y     (s_axis_tdata[67:36]),
        .i_param_t     (s_axis_tdata[85:68]),
        .i_out_ready   (m_axis_tready),
        .o_status      (w_status),
        .o_out_valid   (m_axis_tvalid),
        .o_curve_x     (w_curve_x),
        .o_curve_y     (w_curve_y),
        .o_bad_degree  (m_axis_tuser)
    );

    assign m_axis_tdata = {w_curve_y, w_curve_x};

endmodule

[design/bscp_checker.sv]
// Port-level checker of the B-spline curve point block, bound to the top level.
// Depends on bscp_pkg and bspline_curve_point_assert.svh.
`include "bspline_curve_point_assert.svh"

module bscp_checker import bscp_pkg::*; (
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              s_axis_tvalid,
    input logic              s_axis_tready,
    input logic              s_axis_tuser,
    input logic              m_axis_tvalid,
    input logic              m_axis_tready,
    input logic [63:0]       m_axis_tdata,
    input logic              m_axis_tuser
);

    // A stalled result beat keeps its contents.
    `BSCP_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser), "result beat changed while stalled")

    // A bad-degree result carries a zero point.
    `BSCP_ASSERT_NOW(a_bad_zero, m_axis_tvalid && m_axis_tuser, m_axis_tdata == 64'd0, "bad-degree result with nonzero point")

    // A point write never produces a result.
    `BSCP_ASSERT_NEXT(a_write_silent, s_axis_tvalid && s_axis_tready && (s_axis_tuser == OPC_WRITE) && !m_axis_tvalid, !m_axis_tvalid, "result appeared after a point write")

    // An evaluation holds off the next item.
    `BSCP_ASSERT_NEXT(a_eval_busy, s_axis_tvalid && s_axis_tready && (s_axis_tuser == OPC_EVAL), !s_axis_tready, "input ready right after an evaluation beat")

endmodule

bind bspline_curve_point bscp_checker u_bscp_checker (.*);
